// ----- rtl/core/srtf_preemptive_scheduler_macros.svh -----
// Assertion helpers shared by the scheduler RTL.
`ifndef SRTF_PREEMPTIVE_SCHEDULER_MACROS_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SRTF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SRTF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- rtl/core/srtf_pkg.sv -----
`timescale 1ns / 1ps
package srtf_pkg;

  localparam int unsigned MAX_PROCS_DEF  = 16;
  localparam int unsigned CMDQ_DEPTH_DEF = 2;

  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned TIME_W     = 24;
  localparam int unsigned SUM_W      = 28;
  localparam int unsigned ID_W       = 4;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned IN_TDATA_W = 32;
  localparam int unsigned OUT_TDATA_W = 160;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

  typedef enum logic [ACTION_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_now;
    logic              served_valid;
    logic [ID_W-1:0]   served_id;
    logic              finished;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting_time;
    logic              all_done;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_waiting;
    logic              rejected;
  } result_t;

endpackage

// ----- rtl/core/srtf_ram.sv -----
`timescale 1ns / 1ps
module srtf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/srtf_cmd_queue.sv -----
`timescale 1ns / 1ps
module srtf_cmd_queue #(
  parameter int unsigned Depth = srtf_pkg::CMDQ_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  srtf_pkg::cmd_t push_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output srtf_pkg::cmd_t pop_o
);
  import srtf_pkg::*;

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW = $clog2(Depth + 1);

  cmd_t          mem_q [Depth];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] fill_q, fill_d;
  logic          push, pop;

  assign push_ready_o = (fill_q != NW'(Depth));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

// ----- rtl/core/srtf_engine.sv -----
`timescale 1ns / 1ps
`include "srtf_preemptive_scheduler_macros.svh"
module srtf_engine #(
  parameter int unsigned MaxProcs = srtf_pkg::MAX_PROCS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  srtf_pkg::cmd_t    cmd_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output srtf_pkg::result_t res_o
);
  import srtf_pkg::*;

  localparam int unsigned IW = $clog2(MaxProcs);
  localparam int unsigned CW = $clog2(MaxProcs + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_ACC_T  = 6'b001000,
    ST_ACC_W  = 6'b010000,
    ST_RESP   = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     proc_cnt_q, proc_cnt_d;
  logic [CW-1:0]     done_cnt_q, done_cnt_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [SUM_W-1:0]  sum_t_q, sum_t_d;
  logic [SUM_W-1:0]  sum_w_q, sum_w_d;
  logic [CW-1:0]     scan_idx_q, scan_idx_d;
  logic              pend_q, pend_d;
  logic [IW-1:0]     pend_idx_q, pend_idx_d;
  logic              found_q, found_d;
  logic [IW-1:0]     best_idx_q, best_idx_d;
  logic [FIELD_W-1:0] best_rem_q, best_rem_d;
  logic [FIELD_W-1:0] best_arr_q, best_arr_d;
  logic [FIELD_W-1:0] best_bur_q, best_bur_d;
  logic              st_served_q, st_served_d;
  logic [ID_W-1:0]   st_id_q, st_id_d;
  logic              st_fin_q, st_fin_d;
  logic [TIME_W-1:0] st_comp_q, st_comp_d;
  logic [TIME_W-1:0] st_tat_q, st_tat_d;
  logic [TIME_W-1:0] st_wt_q, st_wt_d;
  logic              st_rej_q, st_rej_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic               arr_we, bur_we, rem_we;
  logic [IW-1:0]      waddr;
  logic [FIELD_W-1:0] rem_wdata;
  logic [FIELD_W-1:0] arr_rd, rem_rd, bur_rd;
  logic               cand_elig, cand_better;
  logic [TIME_W-1:0]  time_inc;
  logic [TIME_W-1:0]  bur_ext;
  logic               out_load;

  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [TIME_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  srtf_ram #(.Width(FIELD_W), .Depth(MaxProcs)) u_arr_ram (
    .clk_i   (clk_i),
    .we_i    (arr_we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.arrival),
    .raddr_i (scan_idx_q[IW-1:0]),
    .rdata_o (arr_rd)
  );

  srtf_ram #(.Width(FIELD_W), .Depth(MaxProcs)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (waddr),
    .wdata_i (rem_wdata),
    .raddr_i (scan_idx_q[IW-1:0]),
    .rdata_o (rem_rd)
  );

  srtf_ram #(.Width(FIELD_W), .Depth(MaxProcs)) u_bur_ram (
    .clk_i   (clk_i),
    .we_i    (bur_we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.burst),
    .raddr_i (scan_idx_q[IW-1:0]),
    .rdata_o (bur_rd)
  );

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // Candidate from the slot read last cycle.
  assign cand_elig   = (TIME_W'(arr_rd) <= time_q) && (rem_rd != '0);
  assign cand_better = !found_q || (rem_rd < best_rem_q) ||
                       ((rem_rd == best_rem_q) && (arr_rd < best_arr_q));
  assign time_inc    = (time_q != TIME_MAX) ? time_q + 1'b1 : time_q;
  assign bur_ext     = TIME_W'(best_bur_q);
  assign out_load    = (state_q == ST_RESP) && (!out_valid_q || res_ready_i);

  always_comb begin
    state_d     = state_q;
    proc_cnt_d  = proc_cnt_q;
    done_cnt_d  = done_cnt_q;
    time_d      = time_q;
    sum_t_d     = sum_t_q;
    sum_w_d     = sum_w_q;
    scan_idx_d  = scan_idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_rem_d  = best_rem_q;
    best_arr_d  = best_arr_q;
    best_bur_d  = best_bur_q;
    st_served_d = st_served_q;
    st_id_d     = st_id_q;
    st_fin_d    = st_fin_q;
    st_comp_d   = st_comp_q;
    st_tat_d    = st_tat_q;
    st_wt_d     = st_wt_q;
    st_rej_d    = st_rej_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    arr_we      = 1'b0;
    bur_we      = 1'b0;
    rem_we      = 1'b0;
    waddr       = proc_cnt_q[IW-1:0];
    rem_wdata   = cmd_i.burst;

    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          st_served_d = 1'b0;
          st_id_d     = '0;
          st_fin_d    = 1'b0;
          st_comp_d   = '0;
          st_tat_d    = '0;
          st_wt_d     = '0;
          st_rej_d    = 1'b0;
          state_d     = ST_RESP;
          case (cmd_i.op)
            OP_CLEAR: begin
              proc_cnt_d = '0;
              done_cnt_d = '0;
              time_d     = '0;
              sum_t_d    = '0;
              sum_w_d    = '0;
              scan_idx_d = '0;
            end
            OP_ADD: begin
              if (proc_cnt_q == CW'(MaxProcs)) begin
                st_rej_d = 1'b1;
              end else begin
                arr_we     = 1'b1;
                bur_we     = 1'b1;
                rem_we     = 1'b1;
                st_id_d    = ID_W'(proc_cnt_q);
                proc_cnt_d = proc_cnt_q + 1'b1;
              end
            end
            OP_TICK: begin
              scan_idx_d = '0;
              pend_d     = 1'b0;
              found_d    = 1'b0;
              state_d    = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (pend_q && cand_elig && cand_better) begin
          found_d    = 1'b1;
          best_idx_d = pend_idx_q;
          best_rem_d = rem_rd;
          best_arr_d = arr_rd;
          best_bur_d = bur_rd;
        end
        if (scan_idx_q < proc_cnt_q) begin
          pend_d     = 1'b1;
          pend_idx_d = scan_idx_q[IW-1:0];
          scan_idx_d = scan_idx_q + 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        time_d = time_inc;
        if (found_q) begin
          st_served_d = 1'b1;
          st_id_d     = ID_W'(best_idx_q);
          rem_we      = 1'b1;
          waddr       = best_idx_q;
          rem_wdata   = best_rem_q - 1'b1;
          if (best_rem_q == FIELD_W'(1)) begin
            st_fin_d  = 1'b1;
            st_comp_d = time_inc;
            st_tat_d  = time_inc - TIME_W'(best_arr_q);
          end
        end
        state_d = ST_ACC_T;
      end
      ST_ACC_T: begin
        if (st_fin_q) begin
          st_wt_d = (st_tat_q >= bur_ext) ? st_tat_q - bur_ext : '0;
          sum_t_d = sat_add(sum_t_q, st_tat_q);
        end
        state_d = ST_ACC_W;
      end
      ST_ACC_W: begin
        if (st_fin_q) begin
          sum_w_d    = sat_add(sum_w_q, st_wt_q);
          done_cnt_d = done_cnt_q + 1'b1;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_load) begin
          out_valid_d           = 1'b1;
          out_d.time_now        = time_q;
          out_d.served_valid    = st_served_q;
          out_d.served_id       = st_id_q;
          out_d.finished        = st_fin_q;
          out_d.completion_time = st_comp_q;
          out_d.turnaround      = st_tat_q;
          out_d.waiting_time    = st_wt_q;
          out_d.all_done        = (done_cnt_q == proc_cnt_q);
          out_d.total_turnaround = sum_t_q;
          out_d.total_waiting   = sum_w_q;
          out_d.rejected        = st_rej_q;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      proc_cnt_q  <= '0;
      done_cnt_q  <= '0;
      time_q      <= '0;
      sum_t_q     <= '0;
      sum_w_q     <= '0;
      scan_idx_q  <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      proc_cnt_q  <= proc_cnt_d;
      done_cnt_q  <= done_cnt_d;
      time_q      <= time_d;
      sum_t_q     <= sum_t_d;
      sum_w_q     <= sum_w_d;
      scan_idx_q  <= scan_idx_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= pend_idx_d;
    best_idx_q  <= best_idx_d;
    best_rem_q  <= best_rem_d;
    best_arr_q  <= best_arr_d;
    best_bur_q  <= best_bur_d;
    st_served_q <= st_served_d;
    st_id_q     <= st_id_d;
    st_fin_q    <= st_fin_d;
    st_comp_q   <= st_comp_d;
    st_tat_q    <= st_tat_d;
    st_wt_q     <= st_wt_d;
    st_rej_q    <= st_rej_d;
    out_q       <= out_d;
  end

  `SRTF_ASSERT_IMP(a_done_le_procs, 1'b1, done_cnt_q <= proc_cnt_q)
  `SRTF_ASSERT_IMP(a_scan_in_table, 1'b1, scan_idx_q <= proc_cnt_q)
  `SRTF_ASSERT_NXT(a_fin_is_served, out_load && st_fin_q, out_q.served_valid && (out_q.time_now != '0))

endmodule

// ----- rtl/core/srtf_preemptive_scheduler.sv -----
`timescale 1ns / 1ps
// Preemptive shortest-remaining-time-first scheduler with a table of up to
// MaxProcs processes. Each input item is one action (clear, add, tick) and
// yields exactly one result item. Items enter a short command queue, so up to
// QueueDepth items are taken while the scheduling engine is busy or while a
// result waits to be taken; once the queue is full the input stalls until the
// engine takes the next item. Clear, add and the unused action go from idle
// straight to the response state; a tick first scans the loaded processes,
// reading one table slot per cycle through the read ports of the arrival,
// remaining-time and burst memories, then updates the chosen process and
// accumulates the turnaround and waiting totals. The process stores need no
// clearing pass after reset: only slots below the process count are used.
module srtf_preemptive_scheduler #(
  parameter int unsigned MaxProcs   = srtf_pkg::MAX_PROCS_DEF,
  parameter int unsigned QueueDepth = srtf_pkg::CMDQ_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // arrival_time [15:0], burst_time [31:16]
  input  logic [srtf_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // action [1:0]
  input  logic [srtf_pkg::ACTION_W-1:0]      s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // time_now [23:0], served_valid [24], served_id [28:25], finished [29],
  // completion_time [53:30], turnaround [77:54], waiting_time [101:78],
  // all_done [102], total_turnaround [130:103], total_waiting [158:131],
  // rejected [159]
  output logic [srtf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);
  import srtf_pkg::*;

  cmd_t    in_cmd;
  cmd_t    q_cmd;
  logic    q_valid, q_ready;
  result_t res;

  // Classify the incoming item: the action code becomes an operation.
  always_comb begin
    in_cmd.arrival = s_axis_tdata_i[FIELD_W-1:0];
    in_cmd.burst   = s_axis_tdata_i[2*FIELD_W-1:FIELD_W];
    case (s_axis_tuser_i)
      OP_CLEAR: in_cmd.op = OP_CLEAR;
      OP_ADD:   in_cmd.op = OP_ADD;
      OP_TICK:  in_cmd.op = OP_TICK;
      default:  in_cmd.op = OP_NOP;
    endcase
  end

  // Hold classified items until the engine is free.
  srtf_cmd_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid_i),
    .push_ready_o (s_axis_tready_o),
    .push_i       (in_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_o        (q_cmd)
  );

  // Carry out one action at a time; the result waits in its output register.
  srtf_engine #(.MaxProcs(MaxProcs)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // Pack the result item, first field in the lowest bits.
  assign m_axis_tdata_o = {res.rejected, res.total_waiting, res.total_turnaround,
                           res.all_done, res.waiting_time, res.turnaround,
                           res.completion_time, res.finished, res.served_id,
                           res.served_valid, res.time_now};

endmodule
